/* src/akl_pkg.sv */
// Shared types, constants and tables for the analog keypad code lock.
package akl_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int KEY_W      = 4;
    localparam int CHAR_W     = 7;
    localparam int DCNT_W     = 3;
    localparam int WAIT_W     = 16;
    localparam int DIGIT_W    = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int N_SECRET   = 4;
    localparam int KEY_BANDS  = 16;

    localparam int DEF_CODE_LENGTH = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SECRET_FIRST  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SECRET_SECOND = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SECRET_THIRD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SECRET_FOURTH = 3'd4;

    localparam logic [WAIT_W-1:0]  RST_DEBOUNCE = 16'd50;
    localparam logic [DIGIT_W-1:0] RST_SECRET_FIRST  = 4'd1;
    localparam logic [DIGIT_W-1:0] RST_SECRET_SECOND = 4'd5;
    localparam logic [DIGIT_W-1:0] RST_SECRET_THIRD  = 4'd9;
    localparam logic [DIGIT_W-1:0] RST_SECRET_FOURTH = 4'd7;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 7'h39;

    // Ladder thresholds, band i lies strictly between entries i and i+1
    localparam logic [SAMPLE_W-1:0] BAND_EDGE [KEY_BANDS+1] = '{
        12'd200,  12'd400,  12'd650,  12'd850,  12'd1100, 12'd1300,
        12'd1500, 12'd1750, 12'd1950, 12'd2200, 12'd2400, 12'd2650,
        12'd2950, 12'd3280, 12'd3600, 12'd3900, 12'd4095
    };

    // Button legend per band
    localparam logic [CHAR_W-1:0] BAND_CHAR [KEY_BANDS] = '{
        7'h31, 7'h34, 7'h37, 7'h41, 7'h32, 7'h35, 7'h38, 7'h30,
        7'h33, 7'h36, 7'h39, 7'h42, 7'h46, 7'h45, 7'h44, 7'h43
    };

    typedef struct packed {
        logic [WAIT_W-1:0]                 debounce;
        logic [N_SECRET-1:0][DIGIT_W-1:0] secret;
    } t_cfg;

    typedef struct packed {
        logic             found;
        logic [KEY_W-1:0] band;
        logic             released;
    } t_band;

    typedef struct packed {
        logic [KEY_W-1:0]  key_index;
        logic [CHAR_W-1:0] key_char;
        logic [DCNT_W-1:0] digits_entered;
        logic              code_complete;
        logic              code_correct;
    } t_result;

endpackage

/* src/akl_cfg.sv */
// Configuration registers: debounce length and secret code digits.
module akl_cfg import akl_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce  <= RST_DEBOUNCE;
            r_cfg.secret[0] <= RST_SECRET_FIRST;
            r_cfg.secret[1] <= RST_SECRET_SECOND;
            r_cfg.secret[2] <= RST_SECRET_THIRD;
            r_cfg.secret[3] <= RST_SECRET_FOURTH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_DEBOUNCE:      r_cfg.debounce  <= i_cfg_data[WAIT_W-1:0];
                REG_SECRET_FIRST:  r_cfg.secret[0] <= i_cfg_data[DIGIT_W-1:0];
                REG_SECRET_SECOND: r_cfg.secret[1] <= i_cfg_data[DIGIT_W-1:0];
                REG_SECRET_THIRD:  r_cfg.secret[2] <= i_cfg_data[DIGIT_W-1:0];
                REG_SECRET_FOURTH: r_cfg.secret[3] <= i_cfg_data[DIGIT_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* src/akl_classify.sv */
// Threshold compare of one ladder sample into a key band.
module akl_classify import akl_pkg::*; (
    input  logic [SAMPLE_W-1:0] i_sample,
    output t_band               o_band
);

    logic [KEY_BANDS-1:0] hit;

    always_comb begin
        for (int i = 0; i < KEY_BANDS; i++) begin
            hit[i] = (i_sample > BAND_EDGE[i]) && (i_sample < BAND_EDGE[i+1]);
        end
    end

    // Bands are disjoint, so at most one hit is set
    always_comb begin
        o_band.found    = |hit;
        o_band.band     = '0;
        for (int i = 0; i < KEY_BANDS; i++) begin
            if (hit[i]) begin
                o_band.band = KEY_W'(i);
            end
        end
        o_band.released = (i_sample <= BAND_EDGE[0]);
    end

endmodule

/* src/akl_core.sv */
// Debounce/release state machine, digit collection and code compare.
module akl_core import akl_pkg::*; #(
    parameter int CODE_LENGTH = DEF_CODE_LENGTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_band   i_band,
    input  t_cfg    i_cfg,
    output logic    o_emit,
    output t_result o_result
);

    localparam int IDX_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_CONFIRM = 2'd1;
    localparam logic [1:0] PH_RELEASE = 2'd2;

    logic [1:0]         r_phase, n_phase;
    logic [KEY_W-1:0]   r_held, n_held;
    logic [WAIT_W-1:0]  r_wait, n_wait;
    logic [DCNT_W-1:0]  r_cnt, n_cnt;
    logic [DIGIT_W-1:0] r_digits [CODE_LENGTH];

    logic [CHAR_W-1:0]  key_char;
    logic               is_digit;
    logic [DIGIT_W-1:0] new_digit;
    logic [IDX_W-1:0]   wr_idx;
    logic [DCNT_W:0]    cnt_inc;
    logic               complete;
    logic               all_match;
    logic [WAIT_W-1:0]  wait_dec;

    assign key_char  = BAND_CHAR[r_held];
    assign is_digit  = (key_char >= CHAR_ZERO) && (key_char <= CHAR_NINE);
    assign new_digit = DIGIT_W'(key_char - CHAR_ZERO);
    assign wr_idx    = r_cnt[IDX_W-1:0];
    assign cnt_inc   = {1'b0, r_cnt} + (DCNT_W+1)'(1);
    assign complete  = is_digit && (cnt_inc >= (DCNT_W+1)'(CODE_LENGTH));
    assign wait_dec  = r_wait - WAIT_W'(1);
    assign o_emit    = (r_phase == PH_RELEASE) && i_band.released;

    // The position being written this tick takes the new digit
    always_comb begin
        all_match = 1'b1;
        for (int i = 0; i < CODE_LENGTH; i++) begin
            if (IDX_W'(i) == wr_idx) begin
                if (new_digit != i_cfg.secret[i % N_SECRET]) all_match = 1'b0;
            end else begin
                if (r_digits[i] != i_cfg.secret[i % N_SECRET]) all_match = 1'b0;
            end
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_held  = r_held;
        n_wait  = r_wait;
        n_cnt   = r_cnt;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_band.found) begin
                    n_held  = i_band.band;
                    n_wait  = (i_cfg.debounce == '0) ? WAIT_W'(1) : i_cfg.debounce;
                    n_phase = PH_CONFIRM;
                end
            end
            PH_CONFIRM: begin
                n_wait = wait_dec;
                if (wait_dec == '0) begin
                    n_phase = (i_band.found && i_band.band == r_held) ? PH_RELEASE
                                                                      : PH_IDLE;
                end
            end
            PH_RELEASE: begin
                if (i_band.released) begin
                    n_phase = PH_IDLE;
                    if (is_digit) begin
                        n_cnt = complete ? '0 : cnt_inc[DCNT_W-1:0];
                    end
                end
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_held  <= '0;
            r_wait  <= '0;
            r_cnt   <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_held  <= n_held;
            r_wait  <= n_wait;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && o_emit && is_digit) begin
            r_digits[wr_idx] <= new_digit;
        end
    end

    always_comb begin
        o_result.key_index      = r_held;
        o_result.key_char       = key_char;
        o_result.digits_entered = n_cnt;
        o_result.code_complete  = complete;
        o_result.code_correct   = complete && all_match;
    end

endmodule

/* src/analog_keypad_code_lock_unit.sv */
// Top level of the resistor-ladder keypad decoder with code lock.
//
// Input channel: one 12-bit ladder sample per word on i_adc_sample, taken when
// i_in_valid is high and o_in_stall is low. Output channel: one key word on
// o_key_index/o_key_char/o_digits_entered/o_code_complete/o_code_correct,
// taken when o_out_valid is high and i_out_stall is low. Only the sample that
// shows key release produces a word; all other samples produce none.
// A taken sample sits in the input register while the classifier and the
// state machine act on it; as it moves on they update and load the result
// register, so the key word passes the input and result registers. One
// sample per cycle is sustained while o_in_stall stays low.
// When the receiver stalls, the result register holds its word; the input
// register still takes a sample, and samples that produce no word keep
// flowing. o_in_stall rises only when a word-producing sample waits behind a
// held result.
// Configuration: i_cfg_we with i_cfg_index (0 debounce ticks, 1..4 secret
// digits) and i_cfg_data; write only while the block is idle.
// Reset (synchronous, active low) returns the state machine to idle, clears
// the digit count and both valid flags, and loads the default configuration.
module analog_keypad_code_lock_unit import akl_pkg::*; #(
    parameter int CODE_LENGTH = DEF_CODE_LENGTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [SAMPLE_W-1:0]   i_adc_sample,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [KEY_W-1:0]      o_key_index,
    output logic [CHAR_W-1:0]     o_key_char,
    output logic [DCNT_W-1:0]     o_digits_entered,
    output logic                  o_code_complete,
    output logic                  o_code_correct,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    cfg;
    t_band   band;
    t_result result;
    logic    emit;
    logic    advance;
    logic    fire;
    logic    accept;

    logic                r_in_valid;
    logic [SAMPLE_W-1:0] r_sample;
    logic                r_out_valid;
    t_result             r_result;

    akl_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    akl_classify u_classify (
        .i_sample (r_sample),
        .o_band   (band)
    );

    akl_core #(
        .CODE_LENGTH (CODE_LENGTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_band   (band),
        .i_cfg    (cfg),
        .o_emit   (emit),
        .o_result (result)
    );

    // Held sample moves on unless it makes a word and the result slot is blocked
    assign advance    = !r_in_valid || !emit || !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample <= i_adc_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && emit) begin
            r_result <= result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_key_index      = r_result.key_index;
    assign o_key_char       = r_result.key_char;
    assign o_digits_entered = r_result.digits_entered;
    assign o_code_complete  = r_result.code_complete;
    assign o_code_correct   = r_result.code_correct;

`ifndef SYNTHESIS
    a_word_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && emit |=> o_out_valid)
        else $error("key word was not loaded into the result register");

    a_correct_needs_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_code_correct |-> o_code_complete)
        else $error("code reported correct without completion");

    a_complete_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_code_complete |-> o_digits_entered == '0)
        else $error("digit count not cleared after completed code");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({1'b0, o_digits_entered} < (DCNT_W+1)'(CODE_LENGTH)))
        else $error("digit count reached the code length");
`endif

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// Testbench for the keypad code lock: directed table, random key presses, scoreboard.
module tb_top;
    import akl_pkg::*;

    typedef enum logic [1:0] {LK_IDLE, LK_CONFIRM, LK_RELEASE} t_lock_phase;

    typedef struct packed {
        logic [SAMPLE_W-1:0] smp;
        logic                typed;
        t_result             want;
    } t_dir_row;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

    localparam logic [SAMPLE_W-1:0] LADDER_EDGE [KEY_BANDS+1] = '{
        12'd200,  12'd400,  12'd650,  12'd850,  12'd1100, 12'd1300,
        12'd1500, 12'd1750, 12'd1950, 12'd2200, 12'd2400, 12'd2650,
        12'd2950, 12'd3280, 12'd3600, 12'd3900, 12'd4095
    };
    // legend: 1 4 7 A 2 5 8 0 3 6 9 B F E D C
    localparam logic [CHAR_W-1:0] KEY_LEGEND [KEY_BANDS] = '{
        7'h31, 7'h34, 7'h37, 7'h41, 7'h32, 7'h35, 7'h38, 7'h30,
        7'h33, 7'h36, 7'h39, 7'h42, 7'h46, 7'h45, 7'h44, 7'h43
    };
    localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'h30;
    localparam logic [CHAR_W-1:0] ASCII_NINE = 7'h39;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 8;

    // debounce is 0 here (acts as 1); secrets still at reset 1 5 9 7
    localparam t_dir_row DIR_TAB [25] = '{
        '{12'd200,  1'b0, '0},                                 // on lowest threshold
        '{12'd4095, 1'b0, '0},                                 // full scale, no key
        '{12'd650,  1'b0, '0},                                 // on a band edge
        '{12'd201,  1'b0, '0},
        '{12'd399,  1'b0, '0},
        '{12'd300,  1'b0, '0},                                 // still held
        '{12'd200,  1'b1, '{4'd0,  7'h31, 3'd1, 1'b0, 1'b0}},
        '{12'd1301, 1'b0, '0},
        '{12'd1499, 1'b0, '0},
        '{12'd0,    1'b1, '{4'd5,  7'h35, 3'd2, 1'b0, 1'b0}},
        '{12'd2401, 1'b0, '0},
        '{12'd2649, 1'b0, '0},
        '{12'd5,    1'b1, '{4'd10, 7'h39, 3'd3, 1'b0, 1'b0}},
        '{12'd3601, 1'b0, '0},
        '{12'd3899, 1'b0, '0},
        '{12'd100,  1'b1, '{4'd14, 7'h44, 3'd3, 1'b0, 1'b0}},  // letter, count kept
        '{12'd1501, 1'b0, '0},
        '{12'd1000, 1'b0, '0},                                 // confirm on other band
        '{12'd0,    1'b0, '0},
        '{12'd651,  1'b0, '0},
        '{12'd849,  1'b0, '0},
        '{12'd0,    1'b1, '{4'd2,  7'h37, 3'd0, 1'b1, 1'b1}},  // code 1597 matches
        '{12'd4094, 1'b0, '0},
        '{12'd3901, 1'b0, '0},
        '{12'd0,    1'b1, '{4'd15, 7'h43, 3'd0, 1'b0, 1'b0}}
    };

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic [SAMPLE_W-1:0]   adc       = '0;
    logic                  out_stall = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_stall;
    logic                  out_valid;
    logic [KEY_W-1:0]      out_key_index;
    logic [CHAR_W-1:0]     out_key_char;
    logic [DCNT_W-1:0]     out_digits;
    logic                  out_complete;
    logic                  out_correct;

    // lock model state and its copy of the registers
    t_lock_phase           lk_phase = LK_IDLE;
    logic [KEY_W-1:0]      lk_key   = '0;
    logic [WAIT_W-1:0]     lk_wait  = '0;
    logic [DCNT_W-1:0]     lk_count = '0;
    logic [DIGIT_W-1:0]    lk_digits [N_SECRET] = '{default: '0};
    logic [WAIT_W-1:0]     cfg_debounce = 16'd50;
    logic [DIGIT_W-1:0]    cfg_secret [N_SECRET] = '{4'd1, 4'd5, 4'd9, 4'd7};

    t_result key_words_due [$];
    int      err_cnt       = 0;
    int      items_sent    = 0;
    int      calm_left     = 0;
    bit      gap_en        = 1'b1;
    bit      long_hold_req = 1'b0;

    analog_keypad_code_lock_unit uut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_adc_sample     (adc),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_key_index      (out_key_index),
        .o_key_char       (out_key_char),
        .o_digits_entered (out_digits),
        .o_code_complete  (out_complete),
        .o_code_correct   (out_correct),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    task automatic flag_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        err_cnt++;
    endtask

    // band index, KEY_BANDS when the sample lies in no band
    function automatic int ladder_band(input logic [SAMPLE_W-1:0] s);
        for (int i = 0; i < KEY_BANDS; i++) begin
            if (s > LADDER_EDGE[i] && s < LADDER_EDGE[i+1]) return i;
        end
        return KEY_BANDS;
    endfunction

    function automatic bit predict_key(input logic [SAMPLE_W-1:0] s, output t_result w);
        int band;
        logic [CHAR_W-1:0] ch;
        bit ok;
        band = ladder_band(s);
        w = '0;
        case (lk_phase)
            LK_IDLE: begin
                if (band < KEY_BANDS) begin
                    lk_key   = band[KEY_W-1:0];
                    lk_wait  = (cfg_debounce == '0) ? 16'd1 : cfg_debounce;
                    lk_phase = LK_CONFIRM;
                end
                return 1'b0;
            end
            LK_CONFIRM: begin
                lk_wait = lk_wait - 16'd1;
                if (lk_wait == '0) lk_phase = (band == int'(lk_key)) ? LK_RELEASE : LK_IDLE;
                return 1'b0;
            end
            default: begin
                if (s > LADDER_EDGE[0]) return 1'b0;
                lk_phase = LK_IDLE;
                ch = KEY_LEGEND[lk_key];
                if (ch >= ASCII_ZERO && ch <= ASCII_NINE) begin
                    lk_digits[lk_count[1:0]] = ch[DIGIT_W-1:0];
                    lk_count = lk_count + 3'd1;
                    if (lk_count >= 3'(DEF_CODE_LENGTH)) begin
                        ok = 1'b1;
                        for (int i = 0; i < DEF_CODE_LENGTH; i++) begin
                            if (lk_digits[i] != cfg_secret[i % N_SECRET]) ok = 1'b0;
                        end
                        w.code_complete = 1'b1;
                        w.code_correct  = ok;
                        lk_count = '0;
                    end
                end
                w.key_index      = lk_key;
                w.key_char       = ch;
                w.digits_entered = lk_count;
                return 1'b1;
            end
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        if (!gap_en) return 0;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 2);
        return $urandom_range(6, 30);
    endfunction

    function automatic logic [SAMPLE_W-1:0] rand_sample(input int lo, input int hi);
        return SAMPLE_W'($urandom_range(lo, hi));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_digit();
        return CFG_DATA_W'($urandom_range(0, 9));
    endfunction

    function automatic logic [SAMPLE_W-1:0] band_sample(input int b);
        return rand_sample(int'(LADDER_EDGE[b]) + 1, int'(LADDER_EDGE[b+1]) - 1);
    endfunction

    // pick the band of the next code digit: aimed at the secret, or any digit
    function automatic int code_band(input bit aim);
        int d;
        d = aim ? int'(cfg_secret[lk_count[1:0]]) : 10;
        if (d > 9) d = $urandom_range(0, 9);
        for (int i = 0; i < KEY_BANDS; i++) begin
            if (KEY_LEGEND[i] == ASCII_ZERO + CHAR_W'(d)) return i;
        end
        return 0;
    endfunction

    // valid stays high across back-to-back words; only dropped for a gap
    task automatic offer_sample(input logic [SAMPLE_W-1:0] s, input bit typed = 1'b0,
                                input t_result want = '0);
        int gap;
        t_result w;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        adc      <= s;
        do @(posedge clk); while (in_stall);
        items_sent++;
        if (predict_key(s, w) || typed) key_words_due.push_back(typed ? want : w);
    endtask

    task automatic press_key(input int band);
        int span;
        span = (cfg_debounce == '0) ? 1 : int'(cfg_debounce);
        offer_sample(band_sample(band));
        for (int i = 1; i < span; i++)
            offer_sample($urandom_range(0, 1) ? band_sample(band) : rand_sample(0, 4095));
        offer_sample(($urandom_range(0, 99) < 88) ? band_sample(band)
                                                  : rand_sample(0, 4095));
        repeat ($urandom_range(0, 3))
            offer_sample(rand_sample(int'(LADDER_EDGE[0]) + 1, 4095));
        offer_sample(rand_sample(0, int'(LADDER_EDGE[0])));
    endtask

    task automatic await_words();
        in_valid <= 1'b0;
        do @(posedge clk); while (key_words_due.size() != 0);
    endtask

    // bring the lock back to idle, then let the pipe run dry
    task automatic settle();
        while (lk_phase != LK_IDLE) offer_sample('0);
        await_words();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_DEBOUNCE:      cfg_debounce  = val;
            REG_SECRET_FIRST:  cfg_secret[0] = val[DIGIT_W-1:0];
            REG_SECRET_SECOND: cfg_secret[1] = val[DIGIT_W-1:0];
            REG_SECRET_THIRD:  cfg_secret[2] = val[DIGIT_W-1:0];
            REG_SECRET_FOURTH: cfg_secret[3] = val[DIGIT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_lock(input logic [CFG_DATA_W-1:0] deb, input logic [CFG_DATA_W-1:0] s0,
                                input logic [CFG_DATA_W-1:0] s1, input logic [CFG_DATA_W-1:0] s2,
                                input logic [CFG_DATA_W-1:0] s3);
        write_reg(REG_DEBOUNCE, deb);
        write_reg(REG_SECRET_FIRST, s0);
        write_reg(REG_SECRET_SECOND, s1);
        write_reg(REG_SECRET_THIRD, s2);
        write_reg(REG_SECRET_FOURTH, s3);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_phase(input int n_items);
        int stop_at;
        int r;
        bit aim;
        stop_at = items_sent + n_items;
        aim = 1'b0;
        while (items_sent < stop_at) begin
            r = $urandom_range(0, 99);
            if (lk_count == '0 && lk_phase == LK_IDLE) aim = 1'($urandom_range(0, 1));
            if (r < 65)      press_key(code_band(aim));
            else if (r < 92) press_key($urandom_range(0, KEY_BANDS - 1));
            else             offer_sample(rand_sample(0, 4095));
        end
    endtask

    task automatic check_key_word();
        t_result want;
        if (key_words_due.size() == 0) begin
            flag_mismatch($sformatf("unexpected key word, index %0d", out_key_index));
            return;
        end
        want = key_words_due.pop_front();
        if (out_key_index !== want.key_index)
            flag_mismatch($sformatf("key_index %0d, want %0d", out_key_index, want.key_index));
        if (out_key_char !== want.key_char)
            flag_mismatch($sformatf("key_char %h, want %h", out_key_char, want.key_char));
        if (out_digits !== want.digits_entered)
            flag_mismatch($sformatf("digits_entered %0d, want %0d", out_digits,
                                    want.digits_entered));
        if (out_complete !== want.code_complete)
            flag_mismatch($sformatf("code_complete %b, want %b", out_complete,
                                    want.code_complete));
        if (out_correct !== want.code_correct)
            flag_mismatch($sformatf("code_correct %b, want %b", out_correct, want.code_correct));
    endtask

    initial begin : key_word_sink
        int hold;
        int calm;
        int r;
        hold = 0;
        calm = 0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) check_key_word();
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold = LONG_HOLD;
            end
            if (hold == 0 && calm > 0) begin
                calm--;
            end else if (hold == 0) begin
                r = $urandom_range(0, 99);
                if (r < 8)       calm = $urandom_range(30, 80);
                else if (r < 30) hold = $urandom_range(1, 3);
                else if (r < 33) hold = $urandom_range(10, 40);
            end
            out_stall <= (hold > 0);
            if (hold > 0) hold--;
        end
    end

    initial begin : stimulus
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(REG_DEBOUNCE, '0);
        cfg_we <= 1'b0;
        foreach (DIR_TAB[i]) offer_sample(DIR_TAB[i].smp, DIR_TAB[i].typed, DIR_TAB[i].want);
        settle();

        // digit extremes; mid-phase the sender waits for every word
        program_lock(16'd1, 16'd0, 16'd9, 16'd0, 16'd9);
        random_phase(100);
        await_words();
        random_phase(80);
        settle();

        // receiver holds off long enough to back the block up
        program_lock(16'd3, rand_digit(), rand_digit(), rand_digit(), rand_digit());
        long_hold_req = 1'b1;
        random_phase(180);
        settle();

        // secret digits out of range never match
        program_lock(16'd2, 16'hFFFA, 16'd3, 16'h000F, 16'd9);
        random_phase(150);
        settle();

        // long debounce, one press only
        gap_en = 1'b0;
        program_lock(16'd64, rand_digit(), rand_digit(), rand_digit(), rand_digit());
        press_key(code_band(1'b1));
        settle();
        gap_en = 1'b1;

        // writes past the last register must be dropped
        program_lock(CFG_DATA_W'($urandom_range(1, 6)), rand_digit(), rand_digit(),
                     rand_digit(), rand_digit());
        write_reg(REG_UNUSED_LO, 16'd1);
        write_reg(REG_UNUSED_HI, 16'hFFFF);
        cfg_we <= 1'b0;
        @(posedge clk);
        random_phase(150);
        settle();

        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin : watchdog
        #(1_500_000 * 12);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

/* filelist.f */
src/akl_pkg.sv
src/akl_cfg.sv
src/akl_classify.sv
src/akl_core.sv
src/analog_keypad_code_lock_unit.sv
test/tb_top.sv
